/* design/assert_macros.svh */
// Assertion helper macros for the 1-Wire bus master.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define OWM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent this edge implies consequent at the next edge.
`define OWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/owm_pkg.sv */
// Package for the 1-Wire bus master: payload structs, codes, register map.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package owm_pkg;

    localparam int CFG_W       = 10;
    localparam int CFG_NUM     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int COUNTER_DEF = 10;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_LINE_LOW    = 2'd1,
        STAT_NO_PRESENCE = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RST_LOW     = 3'd0,
        CFG_PRES_WAIT   = 3'd1,
        CFG_PRES_TAIL   = 3'd2,
        CFG_WR1_LOW     = 3'd3,
        CFG_WR0_LOW     = 3'd4,
        CFG_SLOT_LEN    = 3'd5,
        CFG_RD_LOW      = 3'd6,
        CFG_RD_SAMPLE   = 3'd7
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] CFG_RESET [CFG_NUM] = '{
        10'd480, 10'd70, 10'd410, 10'd10, 10'd60, 10'd65, 10'd3, 10'd10
    };

    // one-hot bus sequencer phase
    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_RST_LOW  = 5'b00010,
        PH_RST_WAIT = 5'b00100,
        PH_RST_TAIL = 5'b01000,
        PH_SLOT     = 5'b10000
    } t_phase;

    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] tx_byte;
        logic       line_level;
    } t_owm_in;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        t_status    status;
    } t_owm_out;

endpackage

`default_nettype wire

/* design/one_wire_bus_master.sv */
// 1-Wire bus master top level: tick-driven sequencer with registered result.
// Depends on owm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Usage
//   Input channel (i_in_valid / o_in_ready / i_in): one transfer per microsecond
//   tick, carrying the sampled bus level and an optional command (reset with
//   presence detect, write byte, read byte). A command given while a sequence
//   is running is dropped, tx_byte included.
//   Output channel (o_out_valid / i_out_ready / o_out): exactly one result per
//   input transfer: open-drain drive, busy and done flags, received byte and
//   status of the last command.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   eight 10-bit timing registers, always ready; write only while idle.
//   Latency: the result is registered at the accepting edge and visible the
//   next cycle. Throughput: one tick per cycle while not stalled, set by the
//   single state update between the input handshake and the result register.
//   Stall: with the result register full and i_out_ready low, o_in_ready drops
//   and the sequencer holds; nothing is lost or repeated.
//   Reset (i_rst_n low, synchronous): sequencer idle, timing registers at
//   their defaults (480/70/410/10/60/65/3/10 us), result register empty.
module one_wire_bus_master #(
    parameter int COUNTER_BITS = owm_pkg::COUNTER_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire owm_pkg::t_owm_in     i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output owm_pkg::t_owm_out         o_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire owm_pkg::t_cfg_idx    i_cfg_index,
    input  wire logic [owm_pkg::CFG_W-1:0] i_cfg_data
);
    import owm_pkg::*;

    // compare width covers both the counter and a sum of two registers
    localparam int CW = ((COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W) + 1;
    localparam logic [CW-1:0] CNT_MAX  = CW'((1 << COUNTER_BITS) - 1);
    localparam logic [CW-1:0] SLOT_MAX = CW'(1 << COUNTER_BITS);

    // clamp a timing register to what the tick counter can reach
    function automatic logic [CW-1:0] cap_cnt(input logic [CFG_W-1:0] v);
        logic [CW-1:0] x;
        x = CW'(v);
        return (x > CNT_MAX) ? CNT_MAX : x;
    endfunction

    // timing registers
    logic [CFG_W-1:0] r_cfg [CFG_NUM];

    // sequencer state
    t_phase                  r_phase, n_phase;
    t_opcode                 r_op, n_op;
    logic [COUNTER_BITS-1:0] r_tick, n_tick;
    logic [2:0]              r_bit, n_bit;
    logic [7:0]              r_shift, n_shift;
    logic                    r_pres, n_pres;
    t_status                 r_stat, n_stat;

    // result register
    logic     r_out_valid;
    t_owm_out r_out, n_out;

    logic in_fire;

    // start-of-tick view after a possible command accept
    t_phase                  s_phase;
    t_opcode                 s_op;
    logic [COUNTER_BITS-1:0] s_tick;
    logic [2:0]              s_bit;
    logic [7:0]              s_shift;
    logic                    s_pres;
    t_status                 s_stat;
    logic                    drive, done;
    logic [CW-1:0]           tc, tc_inc, slen, sidx, low_t;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_NUM; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    always_comb begin
        // command accept: only from idle, the accepting tick is the first tick
        s_phase = r_phase;
        s_op    = r_op;
        s_tick  = r_tick;
        s_bit   = r_bit;
        s_shift = r_shift;
        s_pres  = r_pres;
        s_stat  = r_stat;
        done    = 1'b0;
        drive   = 1'b0;
        if (r_phase == PH_IDLE && i_in.opcode != OP_NONE) begin
            s_op   = i_in.opcode;
            s_stat = STAT_OK;
            s_tick = '0;
            s_bit  = '0;
            s_pres = 1'b0;
            if (i_in.opcode == OP_RESET) begin
                if (!i_in.line_level) begin
                    s_stat = STAT_LINE_LOW;   // bus stuck low, abort at once
                    done   = 1'b1;
                end else begin
                    s_phase = PH_RST_LOW;
                end
            end else begin
                s_shift = (i_in.opcode == OP_WRITE) ? i_in.tx_byte : 8'h00;
                s_phase = PH_SLOT;
            end
        end

        tc     = CW'(s_tick);
        tc_inc = tc + CW'(1);

        // slot geometry: length capped, zero acts as one; sample clamped to slot
        slen = CW'(r_cfg[CFG_SLOT_LEN]);
        if (slen > SLOT_MAX) begin
            slen = SLOT_MAX;
        end
        if (slen == '0) begin
            slen = CW'(1);
        end
        sidx = CW'(r_cfg[CFG_RD_LOW]) + CW'(r_cfg[CFG_RD_SAMPLE]);
        if (sidx > slen - CW'(1)) begin
            sidx = slen - CW'(1);
        end

        n_phase = s_phase;
        n_op    = s_op;
        n_tick  = s_tick;
        n_bit   = s_bit;
        n_shift = s_shift;
        n_pres  = s_pres;
        n_stat  = s_stat;
        low_t   = '0;

        unique case (s_phase)
            PH_IDLE: begin
            end
            PH_RST_LOW: begin
                drive  = 1'b1;
                n_tick = COUNTER_BITS'(tc_inc);
                if (tc_inc >= cap_cnt(r_cfg[CFG_RST_LOW])) begin
                    n_phase = PH_RST_WAIT;
                    n_tick  = '0;
                end
            end
            PH_RST_WAIT: begin
                n_tick = COUNTER_BITS'(tc_inc);
                if (tc_inc >= cap_cnt(r_cfg[CFG_PRES_WAIT])) begin
                    n_phase = PH_RST_TAIL;
                    n_tick  = '0;
                end
            end
            PH_RST_TAIL: begin
                if (tc == '0) begin
                    n_pres = !i_in.line_level;
                end
                if (tc >= cap_cnt(r_cfg[CFG_PRES_TAIL])) begin
                    n_stat  = n_pres ? STAT_OK : STAT_NO_PRESENCE;
                    done    = 1'b1;
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end else begin
                    n_tick = COUNTER_BITS'(tc_inc);
                end
            end
            PH_SLOT: begin
                if (s_op == OP_READ) begin
                    low_t = CW'(r_cfg[CFG_RD_LOW]);
                    if (tc == sidx) begin
                        n_shift[s_bit] = s_shift[s_bit] | i_in.line_level;
                    end
                end else begin
                    low_t = s_shift[s_bit] ? CW'(r_cfg[CFG_WR1_LOW])
                                           : CW'(r_cfg[CFG_WR0_LOW]);
                end
                drive = (tc < low_t);
                if (tc_inc >= slen) begin
                    n_tick = '0;
                    if (&s_bit) begin
                        n_bit   = '0;
                        done    = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_bit = s_bit + 3'd1;
                    end
                end else begin
                    n_tick = COUNTER_BITS'(tc_inc);
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        n_out.drive_low = drive;
        n_out.busy_res  = (n_phase != PH_IDLE);
        n_out.done_res  = done;
        n_out.rx_byte   = (n_op == OP_READ) ? n_shift : 8'h00;
        n_out.status    = n_stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_op        <= OP_NONE;
            r_tick      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_pres      <= 1'b0;
            r_stat      <= STAT_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase <= n_phase;
                r_op    <= n_op;
                r_tick  <= n_tick;
                r_bit   <= n_bit;
                r_shift <= n_shift;
                r_pres  <= n_pres;
                r_stat  <= n_stat;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    // checks
    `OWM_ASSERT(a_phase_onehot, i_clk, i_rst_n, $onehot(r_phase), "phase not one-hot")
    `OWM_ASSERT(a_idle_tick_zero, i_clk, i_rst_n, (r_phase != PH_IDLE) || (r_tick == '0), "tick count left nonzero in idle")
    `OWM_ASSERT(a_done_not_busy, i_clk, i_rst_n, !(r_out_valid && r_out.done_res && r_out.busy_res), "done and busy together")
    `OWM_ASSERT_NEXT(a_busy_tracks_phase, i_clk, i_rst_n, in_fire, r_out.busy_res == (r_phase != PH_IDLE), "busy flag disagrees with phase")

endmodule

`default_nettype wire
